/* hdl/pf_pkg.sv */
// ----------------------------------------------------------------------------
// Prime factorizer package
// Shared widths, result kinds and front/back queue entry type.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CountWidth = $clog2(MaxResults + 1);

  typedef logic [ValueWidth-1:0] value_t;

  typedef enum logic [1:0] {
    KIND_FACTOR = 2'd0,
    KIND_PRIME  = 2'd1,
    KIND_BELOW2 = 2'd2
  } kind_e;

  // Job handed from the classifier to the factoring engine.
  typedef struct packed {
    value_t value;
    logic   below_two;   // value below two, no trial division needed
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_EMIT
  } eng_state_e;

endpackage

/* hdl/pf_if.sv */
// ----------------------------------------------------------------------------
// Prime factorizer channel interfaces
// Valid/ready channels for input numbers and result beats.
// ----------------------------------------------------------------------------
interface pf_in_if;
  import pf_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface pf_out_if;
  import pf_pkg::*;
  logic   valid;
  logic   ready;
  value_t factor;
  logic [1:0] kind;
  logic   last;
  modport source (output valid, output factor, output kind, output last, input ready);
  modport sink (input valid, input factor, input kind, input last, output ready);
endinterface

/* hdl/pf_front.sv */
// ----------------------------------------------------------------------------
// Prime factorizer front end
// Accepts numbers, classifies them, and queues them for the engine.
// ----------------------------------------------------------------------------
module pf_front import pf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  pf_in_if.sink in_i,
  output logic  job_valid_o,
  output job_t  job_o,
  input  logic  job_ready_i
);

  // Two-entry queue.
  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].value     <= in_i.value;
      mem_q[wr_q].below_two <= (in_i.value < value_t'(2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> !$past(pop))
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");

endmodule

/* hdl/pf_divider.sv */
// ----------------------------------------------------------------------------
// Prime factorizer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pf_divider import pf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  value_t dividend_i,
  input  value_t divisor_i,
  output logic   done_o,
  output value_t quot_o,
  output value_t rem_o
);

  localparam int unsigned StepWidth = $clog2(ValueWidth + 1);

  value_t               quot_q, dvs_q;
  logic [ValueWidth:0]  rem_q;
  logic [StepWidth-1:0] step_q;
  logic                 busy_q;
  logic [ValueWidth:0]  trial;
  logic [ValueWidth:0]  shifted;

  assign shifted = {rem_q[ValueWidth-1:0], quot_q[ValueWidth-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign done_o  = busy_q && (step_q == '0);
  assign quot_o  = quot_q;
  assign rem_o   = rem_q[ValueWidth-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q && step_q != '0) begin
      if (!trial[ValueWidth]) begin
        rem_q  <= trial;
        quot_q <= {quot_q[ValueWidth-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        quot_q <= {quot_q[ValueWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepWidth'(ValueWidth);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q - StepWidth'(1);
    end
  end

endmodule

/* hdl/pf_engine.sv */
// ----------------------------------------------------------------------------
// Prime factorizer engine
// Runs trial division on one job and emits its result beats.
// ----------------------------------------------------------------------------
module pf_engine import pf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  pf_out_if.source  out_o
);

  // One pass factors n. The first divisor found proves compositeness; if the
  // bound d > n/d is reached with no factor found yet, the input is prime.
  eng_state_e           state_q, state_d;
  value_t               n_q, d_q;
  logic [CountWidth-1:0] cnt_q;
  logic                 found_q;   // at least one factor already emitted
  value_t               o_fac_q;
  kind_e                o_kind_q;
  logic                 o_last_q;
  logic                 div_start, div_done;
  value_t               quot, rem;

  pf_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(n_q), .divisor_i(d_q),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  assign out_o.valid  = (state_q == ST_EMIT);
  assign out_o.factor = o_fac_q;
  assign out_o.kind   = o_kind_q;
  assign out_o.last   = o_last_q;
  assign job_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = job_i.below_two ? ST_EMIT : ST_CHECK;
      ST_CHECK: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV:   if (div_done) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_EMIT;
      ST_EMIT:  if (out_o.ready) state_d = o_last_q ? ST_IDLE : ST_CHECK;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        n_q      <= job_i.value;
        d_q      <= value_t'(2);
        cnt_q    <= '0;
        found_q  <= 1'b0;
        o_fac_q  <= job_i.value;
        o_kind_q <= KIND_BELOW2;
        o_last_q <= 1'b1;
      end
      ST_DIV: if (div_done) begin
        // Bound: d > n/d ends the search.
        if (d_q > quot) begin
          o_fac_q  <= n_q;
          o_kind_q <= found_q ? KIND_FACTOR : KIND_PRIME;
          o_last_q <= 1'b1;
        end else if (rem == '0) begin
          o_fac_q  <= d_q;
          o_kind_q <= KIND_FACTOR;
          // Cofactor one or the MaxResults limit ends the list.
          o_last_q <= (quot == value_t'(1)) ||
                      (cnt_q == CountWidth'(MaxResults - 1));
          n_q      <= quot;
        end else begin
          d_q      <= d_q + value_t'(1);
        end
      end
      ST_EVAL: ;
      ST_EMIT: if (out_o.ready) begin
        cnt_q   <= cnt_q + CountWidth'(1);
        found_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // Non-emitting divisor steps loop back to the divider.
  eng_state_e state_n;
  always_comb begin
    state_n = state_d;
    if (state_q == ST_DIV && div_done && !(d_q > quot) && rem != '0)
      state_n = ST_CHECK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_n;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid && $stable(o_fac_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o) |=> !job_ready_o)
    else $error("engine took a job while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (o_kind_q == KIND_FACTOR || o_last_q))
    else $error("prime or small result not marked last");

endmodule

/* hdl/prime_factorizer_core.sv */
// ----------------------------------------------------------------------------
// Prime factorizer core
// Trial-division primality test and prime factorization of 32-bit numbers.
// ----------------------------------------------------------------------------
// Each accepted number yields one or more result beats. Zero and one give a
// single beat of kind 2; a prime gives a single beat of kind 1 carrying the
// number; a composite gives its prime factors in ascending order, with
// repeats, as kind 0 beats, the final one marked last. A front queue of two
// entries takes numbers while the engine works, so the input side waits only
// once both entries are filled. Latency depends on the data: every trial
// divisor that does not divide costs a start in ST_CHECK plus a pass of the
// shared bit-serial divider (32 steps, then its done strobe); a divisor that
// divides, or the bound, adds the ST_EVAL state and the output beat. A large
// prime needs up to roughly 65536 trial divisors.
module prime_factorizer_core import pf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pf_in_if.sink    in_i,
  pf_out_if.source out_o
);

  logic job_valid, job_ready;
  job_t job;

  // Front: accepts and classifies numbers into the queue.
  pf_front u_front (
    .clk_i, .rst_ni, .in_i,
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  // Back: trial division and result beats.
  pf_engine u_engine (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .out_o
  );

endmodule
